// ===== hdl/lseg_pkg.sv =====
// Shared types, register indexes, mode codes and constant tables for the LED effect generator.
`default_nettype none
package lseg_pkg;

	localparam int LED_INDEX_W = 6;
	localparam int SINE_W      = 11;

	// configuration register indexes
	localparam logic [2:0] REG_MODE         = 3'd0;
	localparam logic [2:0] REG_BASE_COLOR   = 3'd1;
	localparam logic [2:0] REG_SECOND_COLOR = 3'd2;
	localparam logic [2:0] REG_HEADER_COUNT = 3'd3;
	localparam logic [2:0] REG_RAINBOW_PCT  = 3'd4;
	localparam logic [2:0] REG_DIY_COLOR    = 3'd5;
	localparam logic [2:0] REG_DIY_SEGMENTS = 3'd6;

	// effect modes
	localparam logic [2:0] MODE_OFF       = 3'd0;
	localparam logic [2:0] MODE_SOLID     = 3'd1;
	localparam logic [2:0] MODE_BREATH2S  = 3'd2;
	localparam logic [2:0] MODE_BREATH4S  = 3'd3;
	localparam logic [2:0] MODE_DIY       = 3'd4;
	localparam logic [2:0] MODE_SEGMENTED = 3'd5;
	localparam logic [2:0] MODE_RAINBOW   = 3'd6;
	localparam logic [2:0] MODE_UNUSED    = 3'd7;

	localparam logic [SINE_W-1:0] SINE_ONE = 11'd1024;

	// commands from the controller to the datapath
	typedef struct packed {
		logic                   start;
		logic                   wrap;
		logic                   issue;
		logic                   last;
		logic [LED_INDEX_W-1:0] led_index;
	} lseg_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic [2:0] mode;
		logic       rainbow_end;
		logic       adv;
	} lseg_status_t;

	// 100-step half sine, Q1.10
	function automatic logic [SINE_W-1:0] half_sine(input logic [6:0] idx);
		logic [SINE_W-1:0] v;
		case (idx)
			7'd0: v = 11'd0;       7'd1: v = 11'd32;     7'd2: v = 11'd65;
			7'd3: v = 11'd96;      7'd4: v = 11'd128;    7'd5: v = 11'd160;
			7'd6: v = 11'd191;     7'd7: v = 11'd223;    7'd8: v = 11'd255;
			7'd9: v = 11'd286;     7'd10: v = 11'd316;   7'd11: v = 11'd347;
			7'd12: v = 11'd377;    7'd13: v = 11'd407;   7'd14: v = 11'd436;
			7'd15: v = 11'd465;    7'd16: v = 11'd494;   7'd17: v = 11'd521;
			7'd18: v = 11'd549;    7'd19: v = 11'd575;   7'd20: v = 11'd602;
			7'd21: v = 11'd628;    7'd22: v = 11'd652;   7'd23: v = 11'd677;
			7'd24: v = 11'd701;    7'd25: v = 11'd724;   7'd26: v = 11'd746;
			7'd27: v = 11'd768;    7'd28: v = 11'd790;   7'd29: v = 11'd809;
			7'd30: v = 11'd828;    7'd31: v = 11'd847;   7'd32: v = 11'd864;
			7'd33: v = 11'd882;    7'd34: v = 11'd897;   7'd35: v = 11'd912;
			7'd36: v = 11'd927;    7'd37: v = 11'd940;   7'd38: v = 11'd952;
			7'd39: v = 11'd964;    7'd40: v = 11'd974;   7'd41: v = 11'd983;
			7'd42: v = 11'd992;    7'd43: v = 11'd999;   7'd44: v = 11'd1006;
			7'd45: v = 11'd1012;   7'd46: v = 11'd1016;  7'd47: v = 11'd1020;
			7'd48: v = 11'd1022;   7'd49: v = 11'd1024;  7'd50: v = 11'd1024;
			7'd51: v = 11'd1024;   7'd52: v = 11'd1022;  7'd53: v = 11'd1020;
			7'd54: v = 11'd1016;   7'd55: v = 11'd1012;  7'd56: v = 11'd1006;
			7'd57: v = 11'd999;    7'd58: v = 11'd992;   7'd59: v = 11'd983;
			7'd60: v = 11'd974;    7'd61: v = 11'd964;   7'd62: v = 11'd952;
			7'd63: v = 11'd940;    7'd64: v = 11'd927;   7'd65: v = 11'd912;
			7'd66: v = 11'd897;    7'd67: v = 11'd882;   7'd68: v = 11'd864;
			7'd69: v = 11'd847;    7'd70: v = 11'd828;   7'd71: v = 11'd809;
			7'd72: v = 11'd790;    7'd73: v = 11'd768;   7'd74: v = 11'd746;
			7'd75: v = 11'd724;    7'd76: v = 11'd701;   7'd77: v = 11'd677;
			7'd78: v = 11'd652;    7'd79: v = 11'd628;   7'd80: v = 11'd602;
			7'd81: v = 11'd575;    7'd82: v = 11'd549;   7'd83: v = 11'd521;
			7'd84: v = 11'd494;    7'd85: v = 11'd465;   7'd86: v = 11'd436;
			7'd87: v = 11'd407;    7'd88: v = 11'd377;   7'd89: v = 11'd347;
			7'd90: v = 11'd316;    7'd91: v = 11'd286;   7'd92: v = 11'd255;
			7'd93: v = 11'd223;    7'd94: v = 11'd191;   7'd95: v = 11'd160;
			7'd96: v = 11'd128;    7'd97: v = 11'd96;    7'd98: v = 11'd65;
			7'd99: v = 11'd32;
			default: v = 11'd0;
		endcase
		return v;
	endfunction

	// fixed DIY colours, packed green, red, blue
	function automatic logic [23:0] fixed_color(input logic [2:0] sel);
		logic [23:0] c;
		case (sel)
			3'd0: c = 24'h000000;
			3'd1: c = 24'h00FF00;
			3'd2: c = 24'hFF0000;
			3'd3: c = 24'h0000FF;
			3'd4: c = 24'hFFFF00;
			3'd5: c = 24'hFF00FF;
			3'd6: c = 24'h00FFFF;
			default: c = 24'hFFFFFF;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/lseg_ctrl.sv =====
// Frame controller: accepts ticks and sequences the LED indexes into the datapath.
`default_nettype none
module lseg_ctrl
	import lseg_pkg::*;
#(
	parameter int LEDS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic         frame_tick,
	input  wire lseg_status_t status,
	output lseg_cmd_t         cmd
);

	localparam int CW = (LEDS > 1) ? $clog2(LEDS) : 1;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_RUN  = 1'b1;

	logic          state_q;
	logic [CW-1:0] cnt_q;
	logic          accept;
	logic          go;

	assign in_stall = (state_q == S_RUN);
	assign accept   = in_valid && !in_stall;
	assign go       = accept && frame_tick && (status.mode != MODE_UNUSED);

	always_comb begin
		cmd.wrap      = go && (status.mode == MODE_RAINBOW) && status.rainbow_end;
		cmd.start     = go && !cmd.wrap;
		cmd.issue     = (state_q == S_RUN) && status.adv;
		cmd.last      = (cnt_q == CW'(LEDS - 1));
		cmd.led_index = LED_INDEX_W'(cnt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.start) begin
						state_q <= S_RUN;
						cnt_q   <= '0;
					end
				end
				S_RUN: begin
					if (cmd.issue) begin
						if (cmd.last) begin
							state_q <= S_IDLE;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hdl/lseg_datapath.sv =====
// Datapath: configuration, effect phases and the three-stage colour pipeline.
`default_nettype none
module lseg_datapath
	import lseg_pkg::*;
#(
	parameter int LEDS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [2:0]             cfg_index,
	input  wire logic [63:0]            cfg_data,
	input  wire lseg_cmd_t              cmd,
	output lseg_status_t                status,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [LED_INDEX_W-1:0]      led_index,
	output logic [7:0]                  green,
	output logic [7:0]                  red,
	output logic [7:0]                  blue,
	output logic                        frame_last
);

	localparam logic [7:0] OFS_STEP = 8'(256 / LEDS);
	localparam logic [6:0] REM_STEP = 7'(256 % LEDS);
	localparam logic [6:0] REM_MOD  = 7'(LEDS);

	// configuration
	logic [2:0]  mode_q;
	logic [23:0] base_color_q;
	logic [23:0] second_color_q;
	logic [4:0]  header_count_q;
	logic [6:0]  rainbow_pct_q;
	logic [2:0]  diy_color_q;
	logic [63:0] diy_segments_q;

	// effect state
	logic [5:0]        short_phase_q;
	logic [6:0]        long_phase_q;
	logic [9:0]        rainbow_step_q;
	logic [SINE_W-1:0] sine_q;
	logic [7:0]        wheel_base_q;
	logic [7:0]        ofs_q;
	logic [6:0]        rem_q;

	// pipeline
	logic              adv;
	logic              valid_s1, valid_s2;
	logic              pct_s1, pct_s2;
	logic              last_s1, last_s2;
	logic [LED_INDEX_W-1:0] idx_s1, idx_s2;
	logic [23:0]       color_s1;
	logic [SINE_W-1:0] factor_s1;
	logic [17:0]       prod_s2 [3];

	logic [6:0]  rem_sum;
	logic [7:0]  idx8;
	logic        diy_hit;
	logic [7:0]  pos, w, wa;
	logic [8:0]  w3;
	logic [7:0]  wr, wg, wb;
	logic [23:0] color_d;
	logic [SINE_W-1:0] factor_d;
	logic [7:0]  chan_out [3];

	assign adv = !out_valid || !out_stall;

	always_comb begin
		status.mode        = mode_q;
		status.rainbow_end = (rainbow_step_q >= 10'd1023);
		status.adv         = adv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_BREATH2S;
			base_color_q   <= 24'd255;
			second_color_q <= 24'd0;
			header_count_q <= 5'd16;
			rainbow_pct_q  <= 7'd0;
			diy_color_q    <= 3'd0;
			diy_segments_q <= 64'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:         mode_q         <= cfg_data[2:0];
				REG_BASE_COLOR:   base_color_q   <= cfg_data[23:0];
				REG_SECOND_COLOR: second_color_q <= cfg_data[23:0];
				REG_HEADER_COUNT: header_count_q <= cfg_data[4:0];
				REG_RAINBOW_PCT:  rainbow_pct_q  <= cfg_data[6:0];
				REG_DIY_COLOR:    diy_color_q    <= cfg_data[2:0];
				REG_DIY_SEGMENTS: diy_segments_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// phases advance once per frame, at its start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_phase_q  <= '0;
			long_phase_q   <= '0;
			rainbow_step_q <= '0;
		end else if (cmd.wrap) begin
			rainbow_step_q <= '0;
		end else if (cmd.start) begin
			case (mode_q)
				MODE_BREATH2S, MODE_DIY: begin
					short_phase_q <= (short_phase_q >= 6'd49) ? 6'd0 : short_phase_q + 6'd1;
					long_phase_q  <= '0;
				end
				MODE_BREATH4S: begin
					long_phase_q  <= (long_phase_q >= 7'd99) ? 7'd0 : long_phase_q + 7'd1;
					short_phase_q <= '0;
				end
				MODE_RAINBOW: rainbow_step_q <= rainbow_step_q + 10'd1;
				default: ;
			endcase
		end
	end

	// frame-wide values; wheel offset i*256/LEDS kept as quotient and remainder
	assign rem_sum = rem_q + REM_STEP;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sine_q       <= (mode_q == MODE_BREATH4S) ? half_sine(long_phase_q)
			                                          : half_sine({short_phase_q, 1'b0});
			wheel_base_q <= rainbow_step_q[7:0];
			ofs_q        <= '0;
			rem_q        <= '0;
		end else if (cmd.issue) begin
			if (rem_sum >= REM_MOD) begin
				rem_q <= rem_sum - REM_MOD;
				ofs_q <= ofs_q + OFS_STEP + 8'd1;
			end else begin
				rem_q <= rem_sum;
				ofs_q <= ofs_q + OFS_STEP;
			end
		end
	end

	// stage 1 logic: pick the raw colour of this LED
	assign idx8 = 8'(cmd.led_index);

	always_comb begin
		diy_hit = 1'b0;
		for (int k = 0; k < 4; k++) begin
			if (idx8 >= diy_segments_q[16*k +: 8] &&
			    {1'b0, idx8} < {1'b0, diy_segments_q[16*k +: 8]} +
			                   {1'b0, diy_segments_q[16*k+8 +: 8]}) begin
				diy_hit = 1'b1;
			end
		end
	end

	always_comb begin
		pos = ofs_q + wheel_base_q;
		w   = 8'd255 - pos;
		if (w < 8'd85) begin
			wa = w;
		end else if (w < 8'd170) begin
			wa = w - 8'd85;
		end else begin
			wa = w - 8'd170;
		end
		w3 = {wa, 1'b0} + {1'b0, wa};
		if (w < 8'd85) begin
			wr = 8'd255 - w3[7:0];
			wg = 8'd0;
			wb = w3[7:0];
		end else if (w < 8'd170) begin
			wr = 8'd0;
			wg = w3[7:0];
			wb = 8'd255 - w3[7:0];
		end else begin
			wr = w3[7:0];
			wg = 8'd255 - w3[7:0];
			wb = 8'd0;
		end
	end

	always_comb begin
		factor_d = SINE_ONE;
		case (mode_q)
			MODE_OFF:      color_d = 24'd0;
			MODE_SOLID:    color_d = base_color_q;
			MODE_BREATH2S, MODE_BREATH4S: begin
				color_d  = base_color_q;
				factor_d = sine_q;
			end
			MODE_DIY: begin
				if (diy_hit) begin
					color_d = fixed_color(diy_color_q);
				end else begin
					color_d  = base_color_q;
					factor_d = sine_q;
				end
			end
			MODE_SEGMENTED: color_d = (cmd.led_index < LED_INDEX_W'(header_count_q))
			                          ? base_color_q : second_color_q;
			MODE_RAINBOW: begin
				color_d  = {wg, wr, wb};
				factor_d = SINE_W'(rainbow_pct_q);
			end
			default: color_d = 24'd0;
		endcase
	end

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			valid_s1  <= cmd.issue;
			valid_s2  <= valid_s1;
			out_valid <= valid_s2;
		end
	end

	// stage 3: floor of a Q1.10 product, or of product/100 (x*5243>>19 is exact here)
	always_comb begin
		logic [27:0] q;
		for (int c = 0; c < 3; c++) begin
			q = {13'd0, prod_s2[c][14:0]} * 28'd5243;
			if (!pct_s2) begin
				chan_out[c] = prod_s2[c][17:10];
			end else if (q[27:19] > 9'd255) begin
				chan_out[c] = 8'd255;
			end else begin
				chan_out[c] = q[26:19];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			color_s1  <= color_d;
			factor_s1 <= factor_d;
			pct_s1    <= (mode_q == MODE_RAINBOW);
			idx_s1    <= cmd.led_index;
			last_s1   <= cmd.last;

			for (int c = 0; c < 3; c++) begin
				prod_s2[c] <= {10'd0, color_s1[8*c +: 8]} * {7'd0, factor_s1};
			end
			pct_s2  <= pct_s1;
			idx_s2  <= idx_s1;
			last_s2 <= last_s1;

			blue       <= chan_out[0];
			red        <= chan_out[1];
			green      <= chan_out[2];
			led_index  <= idx_s2;
			frame_last <= last_s2;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/led_strip_effect_generator.sv =====
// Top level of the LED strip effect generator: controller, datapath and ports.
//
// Usage: a transaction on the input channel (in_valid high, in_stall low)
// carries frame_tick. A tick of 1 produces one frame: LEDS result transactions
// on the output channel, LED 0 first, each with its GRB colour, and frame_last
// set on the final LED. A tick of 0, mode 7, or the rainbow tick that follows
// step 1022 produce no result (the latter resets the rainbow step).
// Configuration is written through cfg_we / cfg_index / cfg_data, one register
// a cycle; the user must write it only while no frame is in flight, as the
// block does not enforce this. A taken tick's first LED reaches the output
// register through colour select (as it is issued), multiply and scale stage.
// Throughput: one LED per cycle while the output is not stalled; in_stall stays
// high while the controller issues the LED indexes of the current frame.
// While out_valid and out_stall are high the whole colour pipeline holds and
// the controller holds its LED counter, so no transaction is lost or repeated.
// Reset (arst_n low) clears the effect phases, loads the register defaults
// (mode breath2s, base colour blue, header 16) and empties the pipeline.
`default_nettype none
module led_strip_effect_generator
	import lseg_pkg::*;
#(
	parameter int LEDS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic                   frame_tick,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [LED_INDEX_W-1:0]      led_index,
	output logic [7:0]                  green,
	output logic [7:0]                  red,
	output logic [7:0]                  blue,
	output logic                        frame_last,
	input  wire logic                   cfg_we,
	input  wire logic [2:0]             cfg_index,
	input  wire logic [63:0]            cfg_data
);

	lseg_cmd_t    cmd;
	lseg_status_t status;

	// sequence the LED indexes of each accepted frame
	lseg_ctrl #(
		.LEDS(LEDS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.frame_tick(frame_tick),
		.status    (status),
		.cmd       (cmd)
	);

	// hold the registers and phases; compute and scale each colour
	lseg_datapath #(
		.LEDS(LEDS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.led_index (led_index),
		.green     (green),
		.red       (red),
		.blue      (blue),
		.frame_last(frame_last)
	);

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the LED strip effect generator.
`timescale 1ns / 1ps
module testbench;
	import lseg_pkg::*;

	localparam int LEDS_N      = 16;
	// room for the first LED to come out after the tick, and a whole frame on top
	localparam int QUIET_CYCLES = LEDS_N + 8;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int RANDOM_FRAMES = 70;
	// index beyond the register file: the write must be ignored
	localparam logic [2:0] REG_NONE = 3'd7;

	// 100-step half sine in Q1.10; breath2s walks every second entry
	localparam int BREATH_SINE [100] = '{
		0, 32, 65, 96, 128, 160, 191, 223, 255, 286,
		316, 347, 377, 407, 436, 465, 494, 521, 549, 575,
		602, 628, 652, 677, 701, 724, 746, 768, 790, 809,
		828, 847, 864, 882, 897, 912, 927, 940, 952, 964,
		974, 983, 992, 999, 1006, 1012, 1016, 1020, 1022, 1024,
		1024, 1024, 1022, 1020, 1016, 1012, 1006, 999, 992, 983,
		974, 964, 952, 940, 927, 912, 897, 882, 864, 847,
		828, 809, 790, 768, 746, 724, 701, 677, 652, 628,
		602, 575, 549, 521, 494, 465, 436, 407, 377, 347,
		316, 286, 255, 223, 191, 160, 128, 96, 65, 32
	};

	// DIY override colours, packed green, red, blue
	localparam bit [23:0] DIY_PALETTE [8] = '{
		24'h000000, 24'h00FF00, 24'hFF0000, 24'h0000FF,
		24'hFFFF00, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
	};

	typedef struct packed {
		logic [LED_INDEX_W-1:0] pos;
		logic [7:0]             green;
		logic [7:0]             red;
		logic [7:0]             blue;
		logic                   last;
	} led_beat_t;

	// Mirrors the registers and effect phases, predicts every LED of a frame
	// and checks the LED transactions in order.
	class frame_scoreboard;
		bit [2:0]  mode         = MODE_BREATH2S;
		bit [23:0] base_color   = 24'h0000FF;
		bit [23:0] second_color = 24'h000000;
		bit [4:0]  header_count = 5'd16;
		bit [6:0]  rainbow_pct  = 7'd0;
		bit [2:0]  diy_color    = 3'd0;
		bit [63:0] diy_segments = 64'd0;
		bit [5:0]  short_phase  = 6'd0;
		bit [6:0]  long_phase   = 7'd0;
		bit [9:0]  rainbow_step = 10'd0;
		led_beat_t leds_due[$];
		int        faults;

		function void write_reg(logic [2:0] idx, logic [63:0] val);
			case (idx)
				REG_MODE:         mode = val[2:0];
				REG_BASE_COLOR:   base_color = val[23:0];
				REG_SECOND_COLOR: second_color = val[23:0];
				REG_HEADER_COUNT: header_count = val[4:0];
				REG_RAINBOW_PCT:  rainbow_pct = val[6:0];
				REG_DIY_COLOR:    diy_color = val[2:0];
				REG_DIY_SEGMENTS: diy_segments = val;
				default: ;
			endcase
		endfunction

		function bit [23:0] breathe(bit [23:0] c, int s);
			int g, r, b;
			g = (int'(c[23:16]) * s) >> 10;
			r = (int'(c[15:8]) * s) >> 10;
			b = (int'(c[7:0]) * s) >> 10;
			return {g[7:0], r[7:0], b[7:0]};
		endfunction

		function bit [7:0] dim(int v);
			int x;
			x = v * int'(rainbow_pct) / 100;
			return (x > 255) ? 8'd255 : x[7:0];
		endfunction

		function bit [23:0] wheel_colour(int pos);
			int w, g, r, b;
			w = 255 - (pos & 255);
			if (w < 85) begin
				r = 255 - w * 3; g = 0; b = w * 3;
			end else if (w < 170) begin
				w -= 85;
				r = 0; g = w * 3; b = 255 - w * 3;
			end else begin
				w -= 170;
				r = w * 3; g = 255 - w * 3; b = 0;
			end
			return {dim(g), dim(r), dim(b)};
		endfunction

		function void note_tick(logic tick);
			bit [23:0] row [LEDS_N];
			bit [23:0] fill;
			int first, span, p;
			if (tick !== 1'b1 || mode == MODE_UNUSED)
				return;
			fill = 24'h0;
			case (mode)
				MODE_SOLID: fill = base_color;
				MODE_BREATH2S, MODE_DIY: begin
					fill = breathe(base_color, BREATH_SINE[2 * int'(short_phase)]);
					short_phase = (short_phase == 6'd49) ? 6'd0 : short_phase + 6'd1;
					long_phase = 7'd0;
				end
				MODE_BREATH4S: begin
					fill = breathe(base_color, BREATH_SINE[long_phase]);
					long_phase = (long_phase == 7'd99) ? 7'd0 : long_phase + 7'd1;
					short_phase = 6'd0;
				end
				MODE_RAINBOW: begin
					if (rainbow_step >= 10'd1023) begin
						rainbow_step = 10'd0;
						return;
					end
				end
				default: ;
			endcase
			for (int i = 0; i < LEDS_N; i++) begin
				row[i] = fill;
				if (mode == MODE_SEGMENTED)
					row[i] = (i < header_count) ? base_color : second_color;
				if (mode == MODE_RAINBOW)
					row[i] = wheel_colour(i * 256 / LEDS_N + int'(rainbow_step));
			end
			if (mode == MODE_DIY) begin
				for (int k = 0; k < 4; k++) begin
					first = diy_segments[16 * k +: 8];
					span = diy_segments[16 * k + 8 +: 8];
					for (p = first; p < first + span; p++)
						if (p < LEDS_N)
							row[p] = DIY_PALETTE[diy_color];
				end
			end
			if (mode == MODE_RAINBOW)
				rainbow_step++;
			for (int i = 0; i < LEDS_N; i++)
				leds_due.push_back({LED_INDEX_W'(i), row[i], (i == LEDS_N - 1)});
		endfunction

		function void check_led(led_beat_t got);
			led_beat_t exp;
			if (leds_due.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("LED %0d g=%02h r=%02h b=%02h last=%0b with nothing expected",
						got.pos, got.green, got.red, got.blue, got.last);
				return;
			end
			exp = leds_due.pop_front();
			if (got.pos !== exp.pos || got.green !== exp.green || got.red !== exp.red ||
				got.blue !== exp.blue || got.last !== exp.last) begin
				faults++;
				if (faults <= 10)
					$display("LED mismatch: expected idx=%0d g=%02h r=%02h b=%02h last=%0b, %s",
						exp.pos, exp.green, exp.red, exp.blue, exp.last,
						$sformatf("got idx=%0d g=%02h r=%02h b=%02h last=%0b",
							got.pos, got.green, got.red, got.blue, got.last));
			end
		endfunction

		function int waiting();
			return leds_due.size();
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n     = 1'b0;
	logic                   in_valid   = 1'b0;
	logic                   in_stall;
	logic                   frame_tick = 1'b0;
	logic                   out_valid;
	logic                   out_stall  = 1'b0;
	logic [LED_INDEX_W-1:0] led_index;
	logic [7:0]             green;
	logic [7:0]             red;
	logic [7:0]             blue;
	logic                   frame_last;
	logic                   cfg_we     = 1'b0;
	logic [2:0]             cfg_index  = 3'd0;
	logic [63:0]            cfg_data   = 64'd0;

	frame_scoreboard frames = new;
	bit  calm;           // suppress idling on both sides
	int  cycle_count;
	int  frames_asked;   // ticks that should produce a frame

	led_strip_effect_generator #(.LEDS(LEDS_N)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.frame_tick (frame_tick),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.led_index  (led_index),
		.green      (green),
		.red        (red),
		.blue       (blue),
		.frame_last (frame_last),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sample both channels at the rising edge: note each accepted tick in the
	// predictor, then check each accepted LED transaction against the oldest
	// expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				frames.note_tick(frame_tick);
			if (out_valid && !out_stall)
				frames.check_led({led_index, green, red, blue, frame_last});
		end
	end

	// Stall the result channel at random, except during a calm stretch.
	always @(negedge clk)
		out_stall <= !calm && ($urandom_range(99) < 34);

	// Abort a hung run; the limit is many times the slowest correct run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("testbench NOT OK");
			$finish;
		end
	end

	// Offer one tick transaction and hold it until the block takes it; idle
	// beforehand at random. Called and returns at a falling edge.
	task automatic send_tick(input logic tick);
		while (!calm && $urandom_range(99) < 34)
			@(negedge clk);
		in_valid = 1'b1;
		frame_tick = tick;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Hold the sender until every predicted LED has come out.
	task automatic await_empty();
		while (frames.waiting() != 0)
			@(negedge clk);
	endtask

	// Drain, then wait QUIET_CYCLES so that even a tick that makes no LEDs has time
	// to leave the controller and register writes land on an idle block.
	task automatic settle();
		await_empty();
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	task automatic set_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		frames.write_reg(idx, val);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_tick(1'b1);
	endtask

	// Pad a register value with junk above its width now and then; the block
	// must drop the upper bits.
	function automatic logic [63:0] with_junk(logic [63:0] val, int width);
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		if ($urandom_range(3) == 0 && width < 64)
			return val | (junk << width);
		return val;
	endfunction

	function automatic logic [23:0] pick_colour();
		case ($urandom_range(3))
			0: return 24'h000000;
			1: return 24'hFFFFFF;
			default: return 24'($urandom);
		endcase
	endfunction

	// Four segments, mostly short ones inside the strip, some reaching far
	// beyond it, some unused.
	function automatic logic [63:0] pick_segments();
		logic [63:0] segs;
		logic [7:0] first, span;
		if ($urandom_range(7) == 0)
			return {$urandom, $urandom};
		for (int k = 0; k < 4; k++) begin
			first = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(17));
			case ($urandom_range(7))
				0, 1: span = 8'd0;
				2: span = 8'($urandom_range(255));
				default: span = 8'($urandom_range(1, 8));
			endcase
			segs[16 * k +: 16] = {span, first};
		end
		return segs;
	endfunction

	initial begin
		logic [2:0] pick;
		int         burst;
		logic       tick;

		calm = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset defaults: breath2s on blue, with an idle tick in between
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);

		settle();
		set_reg(REG_MODE, 64'(MODE_OFF));
		send_ticks(1);

		settle();
		set_reg(REG_MODE, 64'(MODE_SOLID));
		set_reg(REG_BASE_COLOR, 64'hFFFFFF);
		send_ticks(1);

		// breath4s clears the short phase; breath2s then clears the long one
		settle();
		set_reg(REG_MODE, 64'(MODE_BREATH4S));
		send_ticks(2);
		settle();
		set_reg(REG_MODE, 64'(MODE_BREATH2S));
		send_ticks(1);

		// DIY: one LED at the start, one running off the end, one starting
		// beyond the strip and one unused segment
		settle();
		set_reg(REG_MODE, 64'(MODE_DIY));
		set_reg(REG_DIY_COLOR, 64'd7);
		set_reg(REG_DIY_SEGMENTS, {16'h0005, 16'hFFFF, 16'hFF0F, 16'h0100});
		send_ticks(1);

		// segmented: empty header, header past the strip, header inside it
		settle();
		set_reg(REG_MODE, 64'(MODE_SEGMENTED));
		set_reg(REG_SECOND_COLOR, 64'hFFFFFF);
		set_reg(REG_HEADER_COUNT, 64'd0);
		send_ticks(1);
		settle();
		set_reg(REG_HEADER_COUNT, 64'd31);
		send_ticks(1);
		settle();
		set_reg(REG_HEADER_COUNT, 64'd5);
		send_ticks(1);

		// rainbow at full, saturating and zero brightness
		settle();
		set_reg(REG_MODE, 64'(MODE_RAINBOW));
		set_reg(REG_RAINBOW_PCT, 64'd100);
		send_ticks(1);
		settle();
		set_reg(REG_RAINBOW_PCT, 64'd127);
		send_ticks(1);
		settle();
		set_reg(REG_RAINBOW_PCT, 64'd0);
		send_ticks(1);

		// unused mode and a write to a missing register: no LEDs, no effect
		settle();
		set_reg(REG_MODE, 64'(MODE_UNUSED));
		set_reg(REG_NONE, {$urandom, $urandom});
		send_tick(1'b1);
		send_tick(1'b0);

		// walk the rainbow along the strip; run the first stretch with no
		// idling at all
		settle();
		set_reg(REG_MODE, 64'(MODE_RAINBOW));
		set_reg(REG_RAINBOW_PCT, 64'($urandom_range(127)));
		calm = 1'b1;
		send_ticks(30);
		settle();
		calm = 1'b0;
		set_reg(REG_RAINBOW_PCT, 64'($urandom_range(127)));
		send_ticks(30);

		// carry both breathing phases through their wrap
		settle();
		set_reg(REG_MODE, 64'(MODE_BREATH4S));
		set_reg(REG_BASE_COLOR, 64'(pick_colour()));
		send_ticks(105);
		settle();
		set_reg(REG_MODE, 64'(MODE_BREATH2S));
		send_ticks(55);

		// random phases: new settings, then a burst of mostly real ticks
		while (frames_asked < RANDOM_FRAMES) begin
			settle();
			pick = ($urandom_range(19) == 0) ? MODE_UNUSED : 3'($urandom_range(6));
			set_reg(REG_MODE, with_junk(64'(pick), 3));
			if ($urandom_range(1))
				set_reg(REG_BASE_COLOR, with_junk(64'(pick_colour()), 24));
			if ($urandom_range(1))
				set_reg(REG_SECOND_COLOR, with_junk(64'(pick_colour()), 24));
			if ($urandom_range(1))
				set_reg(REG_HEADER_COUNT, with_junk(64'($urandom_range(31)), 5));
			if ($urandom_range(1))
				set_reg(REG_RAINBOW_PCT, with_junk(64'($urandom_range(127)), 7));
			if ($urandom_range(1))
				set_reg(REG_DIY_COLOR, with_junk(64'($urandom_range(7)), 3));
			if ($urandom_range(1))
				set_reg(REG_DIY_SEGMENTS, pick_segments());
			burst = $urandom_range(15, 40);
			repeat (burst) begin
				tick = ($urandom_range(9) != 0);
				if (tick && frames.mode != MODE_UNUSED)
					frames_asked++;
				send_tick(tick);
				if ($urandom_range(24) == 0)
					await_empty();
			end
		end

		settle();
		repeat (QUIET_CYCLES) @(negedge clk);
		if (frames.waiting() != 0)
			$display("%0d LED transactions never arrived", frames.waiting());
		if (frames.faults == 0 && frames.waiting() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
